>>> hdl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

  // Largest width or height the block takes.
  localparam int unsigned DimBits  = 16;
  localparam int unsigned DimLimit = (DimBits >= 16) ? 65535 : ((1 << DimBits) - 1);

  localparam int unsigned AccW       = 17;
  localparam int unsigned DimW       = 16;
  localparam int unsigned PixCountW  = 2 * DimW;
  localparam int unsigned QueueDepth = 2;

  localparam logic [AccW-1:0] AccMax      = {AccW{1'b1}};
  localparam logic [AccW-1:0] DimLimitAcc = AccW'(DimLimit);
  localparam logic [AccW-1:0] DimSatAcc   = AccW'(65535);
  localparam logic [AccW-1:0] MaxvalLimit = AccW'(255);

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindPixel  = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic [1:0] ErrBadMagic    = 2'd0;
  localparam logic [1:0] ErrHeaderShort = 2'd1;
  localparam logic [1:0] ErrBadValue    = 2'd2;
  localparam logic [1:0] ErrTruncated   = 2'd3;

  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] Ch6     = 8'h36;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef enum logic [2:0] {
    PhMagic,
    PhWidth,
    PhHeight,
    PhMaxval,
    PhAfter,
    PhPixels,
    PhDone
  } phase_e;

  // One byte as classified by the front stage.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_ws;
    logic       is_cr;
    logic       is_lf;
    logic       is_hash;
    logic       is_digit;
    logic       is_plus;
  } item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            last;
    logic [1:0]      err;
  } result_t;

endpackage

>>> hdl/pps_front.sv
`timescale 1ns / 1ps

module pps_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_file_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output pps_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  pps_pkg::item_t item_q, item_d;
  logic           take;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_comb begin
    item_d          = item_q;
    if (take) begin
      item_d.data     = data_byte_i;
      item_d.eof      = end_of_file_i;
      item_d.is_cr    = (data_byte_i == pps_pkg::ChCr);
      item_d.is_lf    = (data_byte_i == pps_pkg::ChLf);
      item_d.is_ws    = (data_byte_i == pps_pkg::ChSpace) || (data_byte_i == pps_pkg::ChTab) ||
                        (data_byte_i == pps_pkg::ChLf) || (data_byte_i == pps_pkg::ChCr);
      item_d.is_hash  = (data_byte_i == pps_pkg::ChHash);
      item_d.is_digit = (data_byte_i >= pps_pkg::Ch0) && (data_byte_i <= pps_pkg::Ch9);
      item_d.is_plus  = (data_byte_i == pps_pkg::ChPlus);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

>>> hdl/pps_queue.sv
`timescale 1ns / 1ps

module pps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pps_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pps_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (pps_pkg::QueueDepth > 1) ? $clog2(pps_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(pps_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(pps_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(pps_pkg::QueueDepth);

  pps_pkg::item_t  mem_q [pps_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/pps_back.sv
`timescale 1ns / 1ps

module pps_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  pps_pkg::item_t   item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pps_pkg::result_t result_o
);

  localparam int unsigned AccW = pps_pkg::AccW;
  localparam int unsigned DimW = pps_pkg::DimW;
  localparam int unsigned PcW  = pps_pkg::PixCountW;

  pps_pkg::phase_e phase_q, phase_d;

  logic            in_comment_q, in_comment_d;
  logic            in_token_q, in_token_d;
  logic [1:0]      tcc_q, tcc_d;
  logic            token_bad_q, token_bad_d;
  logic            digits_done_q, digits_done_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            dim_bad_q, dim_bad_d;
  logic [PcW-1:0]  pixels_left_q, pixels_left_d;
  logic [1:0]      bip_q, bip_d;
  logic [7:0]      red_q, red_d;
  logic [7:0]      green_q, green_d;
  logic            delim_cr_q, delim_cr_d;

  logic             out_valid_q, out_valid_d;
  pps_pkg::result_t res_q, res_d;

  logic fire;
  logic live;
  logic header_phase;
  logic data_phase;
  logic close_now, close_eof;
  logic skip_lf;
  logic pix_byte;
  logic emit;
  logic [1:0] emit_kind, emit_err;
  logic magic_ok, maxval_bad;
  logic [DimW-1:0] acc_sat16;
  logic [PcW-1:0]  area;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign live         = fire && (phase_q != pps_pkg::PhDone);
  assign header_phase = (phase_q == pps_pkg::PhMagic) || (phase_q == pps_pkg::PhWidth) ||
                        (phase_q == pps_pkg::PhHeight) || (phase_q == pps_pkg::PhMaxval);
  assign data_phase   = (phase_q == pps_pkg::PhAfter) || (phase_q == pps_pkg::PhPixels);

  // A token closes on a delimiter, or on the end marker while it is open.
  assign close_now = live && header_phase && in_token_q && (item_i.eof || item_i.is_ws);
  assign close_eof = item_i.eof;
  assign skip_lf   = (phase_q == pps_pkg::PhAfter) && item_i.is_lf;
  assign pix_byte  = live && data_phase && !item_i.eof && !skip_lf && (pixels_left_q != '0);

  assign magic_ok   = (tcc_q == 2'd2) && !token_bad_q;
  assign maxval_bad = (width_q == '0) || (height_q == '0) || dim_bad_q ||
                      (acc_q == '0) || (acc_q > pps_pkg::MaxvalLimit);
  assign acc_sat16  = (acc_q > pps_pkg::DimSatAcc) ? {DimW{1'b1}} : acc_q[DimW-1:0];
  assign area       = PcW'(width_q) * PcW'(height_q);

  // Next state and result selection.
  always_comb begin
    phase_d   = phase_q;
    emit      = 1'b0;
    emit_kind = pps_pkg::KindError;
    emit_err  = pps_pkg::ErrBadMagic;
    if (live) begin
      if (item_i.eof && !(header_phase && in_token_q)) begin
        emit     = 1'b1;
        emit_err = header_phase ? pps_pkg::ErrHeaderShort : pps_pkg::ErrTruncated;
        phase_d  = pps_pkg::PhDone;
      end else if (close_now) begin
        unique case (phase_q)
          pps_pkg::PhMagic: begin
            if (!magic_ok || close_eof) begin
              emit     = 1'b1;
              emit_err = !magic_ok ? pps_pkg::ErrBadMagic : pps_pkg::ErrHeaderShort;
              phase_d  = pps_pkg::PhDone;
            end else begin
              phase_d = pps_pkg::PhWidth;
            end
          end
          pps_pkg::PhWidth, pps_pkg::PhHeight: begin
            if (close_eof) begin
              emit     = 1'b1;
              emit_err = pps_pkg::ErrHeaderShort;
              phase_d  = pps_pkg::PhDone;
            end else begin
              phase_d = (phase_q == pps_pkg::PhWidth) ? pps_pkg::PhHeight : pps_pkg::PhMaxval;
            end
          end
          default: begin
            emit = 1'b1;
            if (maxval_bad || close_eof) begin
              emit_err = maxval_bad ? pps_pkg::ErrBadValue : pps_pkg::ErrTruncated;
              phase_d  = pps_pkg::PhDone;
            end else begin
              emit_kind = pps_pkg::KindHeader;
              phase_d   = item_i.is_cr ? pps_pkg::PhAfter : pps_pkg::PhPixels;
            end
          end
        endcase
      end else if (data_phase) begin
        if (skip_lf) begin
          phase_d = pps_pkg::PhPixels;
        end else if (pixels_left_q == '0) begin
          phase_d = pps_pkg::PhDone;
        end else if (bip_q == 2'd2) begin
          emit      = 1'b1;
          emit_kind = pps_pkg::KindPixel;
          phase_d   = (pixels_left_q == PcW'(1)) ? pps_pkg::PhDone : pps_pkg::PhPixels;
        end else begin
          phase_d = pps_pkg::PhPixels;
        end
      end
    end
  end

  // Token, header and pixel datapath.
  always_comb begin
    logic [1:0]      b_tcc;
    logic            b_bad;
    logic            b_dd;
    logic [AccW-1:0] b_acc;
    logic [AccW+3:0] prod;
    logic            take;

    in_comment_d  = in_comment_q;
    in_token_d    = in_token_q;
    tcc_d         = tcc_q;
    token_bad_d   = token_bad_q;
    digits_done_d = digits_done_q;
    acc_d         = acc_q;
    width_d       = width_q;
    height_d      = height_q;
    dim_bad_d     = dim_bad_q;
    pixels_left_d = pixels_left_q;
    bip_d         = bip_q;
    red_d         = red_q;
    green_d       = green_q;
    delim_cr_d    = delim_cr_q;

    // A new token starts from cleared token state.
    b_tcc = in_token_q ? tcc_q : 2'd0;
    b_bad = in_token_q ? token_bad_q : 1'b0;
    b_dd  = in_token_q ? digits_done_q : 1'b0;
    b_acc = in_token_q ? acc_q : '0;
    prod  = {b_acc, 3'b000} + {2'b00, b_acc, 1'b0} + (AccW+4)'(item_i.data[3:0]);
    take  = 1'b0;

    if (live && header_phase && !item_i.eof && !close_now) begin
      if (in_token_q) begin
        take = 1'b1;
      end else if (in_comment_q) begin
        if (item_i.is_lf) begin
          in_comment_d = 1'b0;
        end
      end else if (item_i.is_hash) begin
        in_comment_d = 1'b1;
      end else if (!item_i.is_ws) begin
        in_token_d = 1'b1;
        take       = 1'b1;
      end
    end

    if (take) begin
      tcc_d         = (b_tcc == 2'd3) ? b_tcc : b_tcc + 2'd1;
      token_bad_d   = b_bad;
      digits_done_d = b_dd;
      acc_d         = b_acc;
      if (phase_q == pps_pkg::PhMagic) begin
        if ((b_tcc == 2'd0 && item_i.data != pps_pkg::ChP) ||
            (b_tcc == 2'd1 && item_i.data != pps_pkg::Ch6) || (b_tcc >= 2'd2)) begin
          token_bad_d = 1'b1;
        end
      end else if (!b_dd) begin
        if (item_i.is_digit) begin
          acc_d = (prod > (AccW+4)'(pps_pkg::AccMax)) ? pps_pkg::AccMax : prod[AccW-1:0];
        end else if (!(item_i.is_plus && b_tcc == 2'd0)) begin
          digits_done_d = 1'b1;
        end
      end
    end

    if (close_now) begin
      in_token_d = 1'b0;
      if (!close_eof) begin
        delim_cr_d = item_i.is_cr;
      end
      if (phase_q == pps_pkg::PhWidth || phase_q == pps_pkg::PhHeight) begin
        if (acc_q > pps_pkg::DimLimitAcc) begin
          dim_bad_d = 1'b1;
        end
        if (phase_q == pps_pkg::PhWidth) begin
          width_d = acc_sat16;
        end else begin
          height_d = acc_sat16;
        end
      end
      if (phase_q == pps_pkg::PhMaxval) begin
        pixels_left_d = area;
        bip_d         = 2'd0;
      end
    end

    if (pix_byte) begin
      case (bip_q)
        2'd0: begin
          red_d = item_i.data;
          bip_d = 2'd1;
        end
        2'd1: begin
          green_d = item_i.data;
          bip_d   = 2'd2;
        end
        default: begin
          bip_d         = 2'd0;
          pixels_left_d = pixels_left_q - PcW'(1);
        end
      endcase
    end
  end

  // Output register; fields other than those of the result kind read as zero.
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      res_d.kind  = emit_kind;
      case (emit_kind)
        pps_pkg::KindHeader: begin
          res_d.width  = width_q;
          res_d.height = height_q;
        end
        pps_pkg::KindPixel: begin
          res_d.red   = red_q;
          res_d.green = green_q;
          res_d.blue  = item_i.data;
          res_d.alpha = pps_pkg::AlphaOpaque;
          res_d.last  = (pixels_left_q == PcW'(1));
        end
        default: begin
          res_d.err = emit_err;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= pps_pkg::PhMagic;
      in_comment_q  <= 1'b0;
      in_token_q    <= 1'b0;
      tcc_q         <= 2'd0;
      token_bad_q   <= 1'b0;
      digits_done_q <= 1'b0;
      acc_q         <= '0;
      width_q       <= '0;
      height_q      <= '0;
      dim_bad_q     <= 1'b0;
      pixels_left_q <= '0;
      bip_q         <= 2'd0;
      red_q         <= '0;
      green_q       <= '0;
      delim_cr_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      in_comment_q  <= in_comment_d;
      in_token_q    <= in_token_d;
      tcc_q         <= tcc_d;
      token_bad_q   <= token_bad_d;
      digits_done_q <= digits_done_d;
      acc_q         <= acc_d;
      width_q       <= width_d;
      height_q      <= height_d;
      dim_bad_q     <= dim_bad_d;
      pixels_left_q <= pixels_left_d;
      bip_q         <= bip_d;
      red_q         <= red_d;
      green_q       <= green_d;
      delim_cr_q    <= delim_cr_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

>>> hdl/ppm_p6_stream_parser.sv
`timescale 1ns / 1ps

// Binary PPM (P6) parser: one file byte per input item, then an item with
// end_of_file set. It sends one header result (width, height), then one RGBA
// pixel per three data bytes with last_pixel on the final one, or stops at
// a single error result; after that it ignores input until reset. The block
// takes one byte per clock for as long as results are taken: the front stage
// registers and classifies each byte, a two-entry queue decouples it from
// the parser, and the parser updates its state for one byte per cycle into
// an output register. A byte that causes a result passes the front register,
// a queue entry and the output register before the result is presented, and
// waits longer only while earlier items sit queued behind a stalled output.
module ppm_p6_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        last_pixel_o,
  output logic [1:0]  error_code_o
);

  logic             fr_valid, fr_ready;
  pps_pkg::item_t   fr_item;
  logic             q_valid, q_ready;
  pps_pkg::item_t   q_item;
  pps_pkg::result_t result;

  pps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  pps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_item_i (fr_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_item_o  (q_item)
  );

  pps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign result_kind_o  = result.kind;
  assign red_o          = result.red;
  assign green_o        = result.green;
  assign blue_o         = result.blue;
  assign alpha_o        = result.alpha;
  assign image_width_o  = result.width;
  assign image_height_o = result.height;
  assign last_pixel_o   = result.last;
  assign error_code_o   = result.err;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pps_pkg::*;

  localparam int unsigned ImgW         = 7;
  localparam int unsigned ImgH         = 25;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 20;

  localparam result_t NoRes = '0;
  localparam result_t HeaderRes =
    {KindHeader, 8'd0, 8'd0, 8'd0, 8'd0, 16'(ImgW), 16'(ImgH), 1'b0, 2'd0};
  localparam result_t FirstPixRes =
    {KindPixel, 8'h0A, 8'h00, 8'hFF, AlphaOpaque, 16'd0, 16'd0, 1'b0, 2'd0};

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    result_t    want;
  } stim_row_t;

  // Header with a comment, a plus sign, junk after the width digits, a
  // leading zero, maxval at its limit and CR LF before the pixel data. The
  // first data byte is an LF that must be kept as red.
  localparam stim_row_t HeaderRows [25] = '{
    {ChP,     1'b0, 1'b0, NoRes},
    {Ch6,     1'b0, 1'b0, NoRes},
    {ChTab,   1'b0, 1'b0, NoRes},
    {ChHash,  1'b0, 1'b0, NoRes},
    {"z",     1'b0, 1'b0, NoRes},
    {ChLf,    1'b0, 1'b0, NoRes},
    {ChPlus,  1'b0, 1'b0, NoRes},
    {"7",     1'b0, 1'b0, NoRes},
    {"q",     1'b0, 1'b0, NoRes},
    {ChCr,    1'b0, 1'b0, NoRes},
    {"0",     1'b0, 1'b0, NoRes},
    {"2",     1'b0, 1'b0, NoRes},
    {"5",     1'b0, 1'b0, NoRes},
    {ChSpace, 1'b0, 1'b0, NoRes},
    {"2",     1'b0, 1'b0, NoRes},
    {"5",     1'b0, 1'b0, NoRes},
    {"5",     1'b0, 1'b0, NoRes},
    {ChCr,    1'b0, 1'b1, HeaderRes},
    {ChLf,    1'b0, 1'b0, NoRes},
    {8'h0A,   1'b0, 1'b0, NoRes},
    {8'h00,   1'b0, 1'b0, NoRes},
    {8'hFF,   1'b0, 1'b1, FirstPixRes},
    {8'hFF,   1'b0, 1'b0, NoRes},
    {8'h80,   1'b0, 1'b0, NoRes},
    {8'h00,   1'b0, 1'b0, NoRes}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        last_pixel_o;
  logic [1:0]  error_code_o;

  ppm_p6_stream_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .last_pixel_o   (last_pixel_o),
    .error_code_o   (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  result_t     results_due[$];
  int unsigned fault_count = 0;
  int unsigned send_idle   = 0;
  int unsigned recv_stall  = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  // Parser state as the predictor sees it.
  phase_e      pr_phase = PhMagic;
  bit          pr_in_comment, pr_in_token, pr_token_bad, pr_digits_done;
  bit          pr_dim_bad, pr_cr_delim;
  int unsigned pr_token_len, pr_value, pr_width, pr_height;
  int unsigned pr_pixels_left, pr_byte_slot;
  logic [7:0]  pr_red = '0;
  logic [7:0]  pr_green = '0;

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d rgba=%02x%02x%02x%02x w=%0d h=%0d last=%0b err=%0d",
                     r.kind, r.red, r.green, r.blue, r.alpha, r.width, r.height,
                     r.last, r.err);
  endfunction

  task automatic flag_fault(input string why);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", why);
  endtask

  function automatic result_t fail_parse(input logic [1:0] code);
    result_t r;
    r = '0;
    r.kind = KindError;
    r.err = code;
    pr_phase = PhDone;
    return r;
  endfunction

  function automatic void take_token_char(input logic [7:0] c);
    int unsigned idx;
    idx = pr_token_len;
    if (pr_token_len < 3) pr_token_len++;
    if (pr_phase == PhMagic) begin
      if ((idx == 0 && c != ChP) || (idx == 1 && c != Ch6) || idx >= 2) pr_token_bad = 1'b1;
    end else if (!pr_digits_done) begin
      if (c >= Ch0 && c <= Ch9) begin
        pr_value = pr_value * 10 + (c - Ch0);
        if (pr_value > AccMax) pr_value = AccMax;
      end else if (!(c == ChPlus && idx == 0)) begin
        pr_digits_done = 1'b1;
      end
    end
  endfunction

  // A token has ended, by a blank or by the end of the file.
  function automatic bit close_token(input bit at_eof, output result_t r);
    r = '0;
    pr_in_token = 1'b0;
    case (pr_phase)
      PhMagic: begin
        if (pr_token_len != 2 || pr_token_bad) begin
          r = fail_parse(ErrBadMagic);
          return 1'b1;
        end
        if (at_eof) begin
          r = fail_parse(ErrHeaderShort);
          return 1'b1;
        end
        pr_phase = PhWidth;
        return 1'b0;
      end
      PhWidth, PhHeight: begin
        if (pr_value > DimLimit) pr_dim_bad = 1'b1;
        if (pr_phase == PhWidth) pr_width = (pr_value > DimSatAcc) ? DimSatAcc : pr_value;
        else pr_height = (pr_value > DimSatAcc) ? DimSatAcc : pr_value;
        if (at_eof) begin
          r = fail_parse(ErrHeaderShort);
          return 1'b1;
        end
        pr_phase = (pr_phase == PhWidth) ? PhHeight : PhMaxval;
        return 1'b0;
      end
      default: begin
        if (pr_width == 0 || pr_height == 0 || pr_dim_bad || pr_value == 0 ||
            pr_value > MaxvalLimit) begin
          r = fail_parse(ErrBadValue);
          return 1'b1;
        end
        if (at_eof) begin
          r = fail_parse(ErrTruncated);
          return 1'b1;
        end
        pr_pixels_left = pr_width * pr_height;
        pr_byte_slot = 0;
        r.kind = KindHeader;
        r.width = 16'(pr_width);
        r.height = 16'(pr_height);
        pr_phase = pr_cr_delim ? PhAfter : PhPixels;
        return 1'b1;
      end
    endcase
  endfunction

  // Advances the predicted parser by one byte or end marker.
  function automatic bit ppm_parse_byte(input logic [7:0] c, input logic at_eof,
                                        output result_t r);
    bit blank;
    r = '0;
    if (pr_phase == PhDone) return 1'b0;
    if (at_eof) begin
      if (pr_phase <= PhMaxval) begin
        if (pr_in_token) return close_token(1'b1, r);
        r = fail_parse(ErrHeaderShort);
        return 1'b1;
      end
      r = fail_parse(ErrTruncated);
      return 1'b1;
    end
    if (pr_phase == PhAfter || pr_phase == PhPixels) begin
      if (pr_phase == PhAfter) begin
        pr_phase = PhPixels;
        if (c == ChLf) return 1'b0;
      end
      if (pr_pixels_left == 0) begin
        pr_phase = PhDone;
        return 1'b0;
      end
      if (pr_byte_slot == 0) begin
        pr_red = c;
        pr_byte_slot = 1;
        return 1'b0;
      end
      if (pr_byte_slot == 1) begin
        pr_green = c;
        pr_byte_slot = 2;
        return 1'b0;
      end
      pr_byte_slot = 0;
      pr_pixels_left--;
      r.kind = KindPixel;
      r.red = pr_red;
      r.green = pr_green;
      r.blue = c;
      r.alpha = AlphaOpaque;
      r.last = (pr_pixels_left == 0);
      if (pr_pixels_left == 0) pr_phase = PhDone;
      return 1'b1;
    end
    blank = (c == ChSpace || c == ChTab || c == ChLf || c == ChCr);
    if (pr_in_token) begin
      if (blank) begin
        pr_cr_delim = (c == ChCr);
        return close_token(1'b0, r);
      end
      take_token_char(c);
      return 1'b0;
    end
    if (pr_in_comment) begin
      if (c == ChLf) pr_in_comment = 1'b0;
      return 1'b0;
    end
    if (c == ChHash) begin
      pr_in_comment = 1'b1;
      return 1'b0;
    end
    if (blank) return 1'b0;
    pr_in_token = 1'b1;
    pr_token_len = 0;
    pr_token_bad = 1'b0;
    pr_digits_done = 1'b0;
    pr_value = 0;
    take_token_char(c);
    return 1'b0;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic feed_byte(input logic [7:0] b, input logic at_eof, input bit typed,
                           input result_t want);
    result_t predicted;
    bit      fired;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_byte_i = b;
    end_of_file_i = at_eof;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    fired = ppm_parse_byte(b, at_eof, predicted);
    if (typed) results_due.push_back(want);
    else if (fired) results_due.push_back(predicted);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, or one long hold-off when asked.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {result_kind_o, red_o, green_o, blue_o, alpha_o, image_width_o,
              image_height_o, last_pixel_o, error_code_o};
      if (results_due.size() == 0) begin
        flag_fault($sformatf("unexpected result %s", fmt_result(seen)));
      end else begin
        want = results_due.pop_front();
        if (seen !== want)
          flag_fault($sformatf("expected %s, got %s", fmt_result(want), fmt_result(seen)));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no item moved for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned data_left;
    int unsigned cut;
    int unsigned quarter;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    end_of_file_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (HeaderRows[i])
      feed_byte(HeaderRows[i].data, HeaderRows[i].eof, HeaderRows[i].typed,
                HeaderRows[i].want);

    // Remaining pixel data, now and then cut short so that the end marker
    // lands inside the image.
    cut = ($urandom_range(2) == 0) ? $urandom_range(1, 5) : 0;
    data_left = 3 * (ImgW * ImgH - 2) - cut;
    quarter = (data_left + 3) / 4;
    for (int unsigned k = 0; k < data_left; k++) begin
      if (k % quarter == 0) begin
        in_valid_i = 1'b0;
        while (results_due.size() != 0) @(negedge clk_i);
        case (k / quarter)
          0: begin
            send_idle = 0;
            recv_stall = 0;
            hold_request = 1'b1;
          end
          1: begin
            send_idle = 66;
            recv_stall = 0;
          end
          2: begin
            send_idle = 0;
            recv_stall = 66;
          end
          default: begin
            send_idle = 12;
            recv_stall = 12;
          end
        endcase
      end
      feed_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoRes);
    end

    // Whatever follows the end of the image or an error is ignored.
    if (cut != 0) feed_byte(8'($urandom_range(255)), 1'b1, 1'b0, NoRes);
    repeat (4) feed_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoRes);
    feed_byte(8'($urandom_range(255)), 1'b1, 1'b0, NoRes);
    in_valid_i = 1'b0;

    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (results_due.size() != 0)
      flag_fault($sformatf("%0d results never arrived", results_due.size()));
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pps_pkg.sv
hdl/pps_front.sv
hdl/pps_queue.sv
hdl/pps_back.sv
hdl/ppm_p6_stream_parser.sv
dv/tb_top.sv
